FILE: design/rsrm_pkg.sv
// Package for the ramp-sampling regridding MAC: sizes, address widths,
// mode codes, controller states and the store port structs. No dependencies.
`default_nettype none
package rsrm_pkg;

   localparam int IN_SAMPLES   = 256;
   localparam int OUT_SAMPLES  = 256;
   localparam int TRAJECTORIES = 2;

   localparam int IN_AW     = $clog2(IN_SAMPLES);
   localparam int OUT_AW    = $clog2(OUT_SAMPLES);
   localparam int TRAJ_AW   = (TRAJECTORIES > 1) ? $clog2(TRAJECTORIES) : 1;
   localparam int SPAN_DEPTH   = TRAJECTORIES * OUT_SAMPLES;
   localparam int WEIGHT_DEPTH = SPAN_DEPTH * IN_SAMPLES;
   localparam int SPAN_AW   = $clog2(SPAN_DEPTH);
   localparam int WEIGHT_AW = $clog2(WEIGHT_DEPTH);

   localparam int TAP_W   = 8;
   localparam int CNT_W   = ((IN_AW > TAP_W) ? IN_AW : TAP_W) + 1;
   localparam int WORD_W  = 16;
   localparam int PROD_W  = 2 * WORD_W;
   localparam int ACC_W   = PROD_W + IN_AW + 1;
   localparam int OUT_W   = 24;
   localparam int SHIFT_W = 5;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd14;

   typedef enum logic [1:0] {
      MODE_WEIGHT  = 2'd0,
      MODE_SPAN    = 2'd1,
      MODE_SAMPLE  = 2'd2,
      MODE_COMPUTE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 weight_en;
      logic [WEIGHT_AW-1:0] weight_addr;
      logic [WORD_W-1:0]    weight;
      logic                 span_en;
      logic [SPAN_AW-1:0]   span_addr;
      logic [TAP_W-1:0]     first_tap;
      logic [TAP_W-1:0]     last_tap;
      logic                 line_en;
      logic [IN_AW-1:0]     line_addr;
      logic [WORD_W-1:0]    sample_re;
      logic [WORD_W-1:0]    sample_im;
   } store_wr_type;

   typedef struct packed {
      logic [SPAN_AW-1:0]   span_addr;
      logic [WEIGHT_AW-1:0] weight_addr;
      logic [IN_AW-1:0]     line_addr;
   } store_rd_addr_type;

   typedef struct packed {
      logic [TAP_W-1:0]  first_tap;
      logic [TAP_W-1:0]  last_tap;
      logic [WORD_W-1:0] weight;
      logic [WORD_W-1:0] sample_re;
      logic [WORD_W-1:0] sample_im;
   } store_rd_type;

endpackage
`default_nettype wire

FILE: design/ramp_sample_regridding_mac.sv
// Ramp-sampling regridding MAC top level: request decode, tap sequencer,
// multiply-accumulate pipeline, shift/saturate and result register.
// Depends on rsrm_pkg and rsrm_store.
//
// Request channel (req_): tuser carries the mode. Weight, span and sample
// writes land in the memories at the transfer edge and give no result.
// A compute request reads the span of its output point, then walks the
// inclusive tap span one tap per cycle: weight and sample reads, a
// registered multiply, and an accumulate. The sum is shifted right by
// result_shift (floor) and saturated to 24 bits per part.
// A compute passes the span read, the tap loop and a drain before the
// result loads; an empty span or an out-of-range point skips the loop and
// the drain. The loop makes one read per memory per cycle. One request is
// in work at a time; the next is taken in the cycle after the result loads,
// and writes are taken while the block stays idle.
// The result register holds the result while rsp_tready is low; a request
// is still taken, and a later compute waits in its final state until the
// register frees. Reset clears control state and sets result_shift to 14;
// memory contents are undefined until written. csr_wr_en writes
// result_shift at any edge.
`default_nettype none
module ramp_sample_regridding_mac (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // in_index[7:0], out_index[15:8], traj_index[16], weight[32:17],
   // first_tap[40:33], last_tap[48:41], sample_re[64:49], sample_im[80:65]
   input  wire logic [87:0] req_tdata,
   // mode[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_re[23:0], out_im[47:24], clipped[48]
   output logic [55:0]      rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data
);
   import rsrm_pkg::*;

   mode_type                  req_mode;
   logic [7:0]                req_in_index;
   logic [7:0]                req_out_index;
   logic                      req_traj_index;
   logic [WORD_W-1:0]         req_weight;
   logic [TAP_W-1:0]          req_first_tap;
   logic [TAP_W-1:0]          req_last_tap;
   logic [WORD_W-1:0]         req_sample_re;
   logic [WORD_W-1:0]         req_sample_im;
   logic                      req_in_ok;
   logic                      req_pt_ok;
   logic [SPAN_AW-1:0]        req_span;
   logic                      accept;

   state_type                 state_ff, state_in;
   logic [SHIFT_W-1:0]        shift_ff, shift_in;
   logic [SPAN_AW-1:0]        span_ff, span_in;
   logic                      pt_ok_ff, pt_ok_in;
   logic [CNT_W-1:0]          k_ff, k_in;
   logic [CNT_W-1:0]          last_ff, last_in;
   logic                      rd_v_ff, rd_v_in;
   logic                      prod_v_ff, prod_v_in;
   logic signed [PROD_W-1:0]  prod_re_ff, prod_re_in;
   logic signed [PROD_W-1:0]  prod_im_ff, prod_im_in;
   logic signed [ACC_W-1:0]   acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0]   acc_im_ff, acc_im_in;
   logic                      rsp_v_ff, rsp_v_in;
   logic [OUT_W-1:0]          out_re_ff, out_re_in;
   logic [OUT_W-1:0]          out_im_ff, out_im_in;
   logic                      clip_ff, clip_in;

   logic                      issue;
   logic                      load_out;
   logic [CNT_W-1:0]          span_first;
   logic [CNT_W-1:0]          span_last;
   logic                      span_empty;
   logic signed [ACC_W-1:0]   shr_re, shr_im;
   logic                      ovf_re, ovf_im;

   store_wr_type              st_wr;
   store_rd_addr_type         st_rd_addr;
   store_rd_type              st_rd;

   assign req_mode       = mode_type'(req_tuser);
   assign req_in_index   = req_tdata[7:0];
   assign req_out_index  = req_tdata[15:8];
   assign req_traj_index = req_tdata[16];
   assign req_weight     = req_tdata[32:17];
   assign req_first_tap  = req_tdata[40:33];
   assign req_last_tap   = req_tdata[48:41];
   assign req_sample_re  = req_tdata[64:49];
   assign req_sample_im  = req_tdata[80:65];

   assign req_in_ok = 32'(req_in_index) < IN_SAMPLES;
   assign req_pt_ok = (32'(req_out_index) < OUT_SAMPLES)
                   && (32'(req_traj_index) < TRAJECTORIES);
   assign req_span  = SPAN_AW'(32'(req_traj_index) * OUT_SAMPLES + 32'(req_out_index));
   assign accept    = req_tvalid && req_tready;

   // memory ports
   always_comb begin
      st_wr.weight_en   = accept && (req_mode == MODE_WEIGHT) && req_in_ok && req_pt_ok;
      st_wr.weight_addr = WEIGHT_AW'(32'(req_span) * IN_SAMPLES + 32'(req_in_index));
      st_wr.weight      = req_weight;
      st_wr.span_en     = accept && (req_mode == MODE_SPAN) && req_pt_ok;
      st_wr.span_addr   = req_span;
      st_wr.first_tap   = req_first_tap;
      st_wr.last_tap    = req_last_tap;
      st_wr.line_en     = accept && (req_mode == MODE_SAMPLE) && req_in_ok;
      st_wr.line_addr   = IN_AW'(req_in_index);
      st_wr.sample_re   = req_sample_re;
      st_wr.sample_im   = req_sample_im;
      st_rd_addr.span_addr   = req_span;
      st_rd_addr.weight_addr = WEIGHT_AW'(32'(span_ff) * IN_SAMPLES + 32'(k_ff));
      st_rd_addr.line_addr   = IN_AW'(k_ff);
   end

   rsrm_store u_store (
      .clock   (clock),
      .wr      (st_wr),
      .rd_addr (st_rd_addr),
      .rd      (st_rd)
   );

   // span decode, clamp last tap to the line
   assign span_first = CNT_W'(st_rd.first_tap);
   assign span_last  = (CNT_W'(st_rd.last_tap) >= CNT_W'(IN_SAMPLES))
                     ? CNT_W'(IN_SAMPLES - 1) : CNT_W'(st_rd.last_tap);
   assign span_empty = !pt_ok_ff || (span_first > span_last);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_COMPUTE)) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            state_in = span_empty ? ST_DONE : ST_RUN;
         end
         ST_RUN: begin
            if (k_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !prod_v_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_RUN: begin
            issue = 1'b1;
         end
         ST_DONE: begin
            load_out = !rsp_v_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // shift (floor) and saturate
   assign shr_re = acc_re_ff >>> shift_ff;
   assign shr_im = acc_im_ff >>> shift_ff;
   assign ovf_re = !((&shr_re[ACC_W-1:OUT_W-1]) || !(|shr_re[ACC_W-1:OUT_W-1]));
   assign ovf_im = !((&shr_im[ACC_W-1:OUT_W-1]) || !(|shr_im[ACC_W-1:OUT_W-1]));

   // datapath
   always_comb begin
      shift_in   = csr_wr_en ? csr_wr_data : shift_ff;
      span_in    = span_ff;
      pt_ok_in   = pt_ok_ff;
      k_in       = k_ff;
      last_in    = last_ff;
      acc_re_in  = acc_re_ff;
      acc_im_in  = acc_im_ff;
      rd_v_in    = issue;
      prod_v_in  = rd_v_ff;
      prod_re_in = $signed(st_rd.weight) * $signed(st_rd.sample_re);
      prod_im_in = $signed(st_rd.weight) * $signed(st_rd.sample_im);
      rsp_v_in   = rsp_v_ff && !rsp_tready;
      out_re_in  = out_re_ff;
      out_im_in  = out_im_ff;
      clip_in    = clip_ff;

      if (accept && (req_mode == MODE_COMPUTE)) begin
         span_in   = req_span;
         pt_ok_in  = req_pt_ok;
         acc_re_in = '0;
         acc_im_in = '0;
      end
      if (state_ff == ST_SPAN) begin
         k_in    = span_first;
         last_in = span_last;
      end
      if (issue) begin
         k_in = k_ff + CNT_W'(1);
      end
      if (prod_v_ff) begin
         acc_re_in = acc_re_ff + ACC_W'(prod_re_ff);
         acc_im_in = acc_im_ff + ACC_W'(prod_im_ff);
      end
      if (load_out) begin
         rsp_v_in  = 1'b1;
         out_re_in = ovf_re ? {shr_re[ACC_W-1], {(OUT_W-1){!shr_re[ACC_W-1]}}}
                            : shr_re[OUT_W-1:0];
         out_im_in = ovf_im ? {shr_im[ACC_W-1], {(OUT_W-1){!shr_im[ACC_W-1]}}}
                            : shr_im[OUT_W-1:0];
         clip_in   = ovf_re || ovf_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         shift_ff  <= SHIFT_RESET;
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         shift_ff  <= shift_in;
         rd_v_ff   <= rd_v_in;
         prod_v_ff <= prod_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff    <= span_in;
      pt_ok_ff   <= pt_ok_in;
      k_ff       <= k_in;
      last_ff    <= last_in;
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      acc_re_ff  <= acc_re_in;
      acc_im_ff  <= acc_im_in;
      out_re_ff  <= out_re_in;
      out_im_ff  <= out_im_in;
      clip_ff    <= clip_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {7'd0, clip_ff, out_im_ff, out_re_ff};

endmodule
`default_nettype wire

FILE: design/rsrm_store.sv
// Weight, tap span and line buffer memories, one write and one registered
// read port each. Depends on rsrm_pkg.
`default_nettype none
module rsrm_store (
   input  wire logic                       clock,
   input  wire rsrm_pkg::store_wr_type     wr,
   input  wire rsrm_pkg::store_rd_addr_type rd_addr,
   output rsrm_pkg::store_rd_type          rd
);
   import rsrm_pkg::*;

   logic [WORD_W-1:0]    weight_mem [WEIGHT_DEPTH];
   logic [2*TAP_W-1:0]   span_mem   [SPAN_DEPTH];
   logic [2*WORD_W-1:0]  line_mem   [IN_SAMPLES];

   logic [WORD_W-1:0]    weight_ff;
   logic [2*TAP_W-1:0]   span_ff;
   logic [2*WORD_W-1:0]  line_ff;

   always_ff @(posedge clock) begin
      if (wr.weight_en) begin
         weight_mem[wr.weight_addr] <= wr.weight;
      end
      weight_ff <= weight_mem[rd_addr.weight_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.span_en) begin
         span_mem[wr.span_addr] <= {wr.last_tap, wr.first_tap};
      end
      span_ff <= span_mem[rd_addr.span_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.line_en) begin
         line_mem[wr.line_addr] <= {wr.sample_im, wr.sample_re};
      end
      line_ff <= line_mem[rd_addr.line_addr];
   end

   assign rd.first_tap = span_ff[TAP_W-1:0];
   assign rd.last_tap  = span_ff[2*TAP_W-1:TAP_W];
   assign rd.weight    = weight_ff;
   assign rd.sample_re = line_ff[WORD_W-1:0];
   assign rd.sample_im = line_ff[2*WORD_W-1:WORD_W];

endmodule
`default_nettype wire
